@@ src/asp_pkg.sv @@
// ----------------------------------------------------------------------------
// asp_pkg
// shared types, constants and the tone step table of the arcade port device
// ----------------------------------------------------------------------------
package asp_pkg;

  // tone slots
  localparam int SLOT_COUNT = 8;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // field widths
  localparam int OPCODE_W  = 2;
  localparam int PORT_W    = 8;
  localparam int DATA_W    = 8;
  localparam int BUTTONS_W = 5;
  localparam int SAMPLE_W  = 16;
  localparam int TONE_W    = 4;
  localparam int FRAMES_W  = 4;
  localparam int PHASE_W   = 32;
  localparam int SHIFT_W   = 16;
  localparam int AMT_W     = 3;
  localparam int AMP_W     = 15;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 15;
  localparam logic [CFG_IDX_W-1:0] CFG_BLIP_LENGTH    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TONE_AMPLITUDE = 1'd1;
  localparam logic [FRAMES_W-1:0]  BLIP_RESET         = 4'd4;
  localparam logic [AMP_W-1:0]     AMP_RESET          = 15'd8500;

  // i/o port addresses
  localparam logic [PORT_W-1:0] PORT_BUTTONS   = 8'd1;
  localparam logic [PORT_W-1:0] PORT_SHIFT_AMT = 8'd2;
  localparam logic [PORT_W-1:0] PORT_SHIFT_RD  = 8'd3;
  localparam logic [PORT_W-1:0] PORT_TONE_A    = 8'd3;
  localparam logic [PORT_W-1:0] PORT_SHIFT_WR  = 8'd4;
  localparam logic [PORT_W-1:0] PORT_TONE_B    = 8'd5;

  typedef enum logic [OPCODE_W-1:0] {
    OP_READ   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_TICK   = 2'd2,
    OP_SAMPLE = 2'd3
  } asp_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } asp_state_t;

  typedef enum logic [1:0] {
    WK_ALLOC,
    WK_AGE,
    WK_SAMPLE
  } asp_walk_t;

  // sequencer to slot unit
  typedef struct packed {
    logic              start;
    logic              step;
    asp_walk_t         kind;
    logic              bank;
    logic [SLOT_W-1:0] ptr;
  } asp_slot_cmd_t;

  // slot unit to sequencer
  typedef struct packed {
    logic hit;
    logic any_active;
  } asp_slot_stat_t;

  // round(f * 2^32 / 48000) for each tone
  localparam logic [PHASE_W-1:0] PHASE_STEP [16] = '{
    32'd10737418, 32'd23264406, 32'd46528812, 32'd8053064,
    32'd62634940, 32'd12526988, 32'd5368709,  32'd98426334,
    32'd16106127, 32'd8053064,  32'd28633115, 32'd42949673,
    32'd19685267, 32'd13421773, 32'd71582788, 32'd89478485
  };

endpackage

@@ src/asp_if.sv @@
// ----------------------------------------------------------------------------
// asp_item_if / asp_result_if
// valid/ready channels for port items and their results
// ----------------------------------------------------------------------------
interface asp_item_if;
  import asp_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [OPCODE_W-1:0]  opcode;
  logic [PORT_W-1:0]    port;
  logic [DATA_W-1:0]    data;
  logic [BUTTONS_W-1:0] buttons;

  modport source (output valid, opcode, port, data, buttons, input ready);
  modport sink   (input valid, opcode, port, data, buttons, output ready);
endinterface

interface asp_result_if;
  import asp_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [DATA_W-1:0]          read_data;
  logic signed [SAMPLE_W-1:0] audio_sample;
  logic                       tone_active;

  modport source (output valid, read_data, audio_sample, tone_active, input ready);
  modport sink   (input valid, read_data, audio_sample, tone_active, output ready);
endinterface

@@ src/asp_slot_unit.sv @@
// ----------------------------------------------------------------------------
// asp_slot_unit
// tone slot store with one shared slot update datapath and phase accumulator
// ----------------------------------------------------------------------------
module asp_slot_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  asp_pkg::asp_slot_cmd_t        cmd,
  input  logic [asp_pkg::DATA_W-1:0]    tone_bits,
  input  logic [asp_pkg::FRAMES_W-1:0]  blip_length,
  input  logic [asp_pkg::AMP_W-1:0]     tone_amplitude,
  output asp_pkg::asp_slot_stat_t       stat,
  output logic signed [asp_pkg::SAMPLE_W-1:0] sample
);
  import asp_pkg::*;

  logic [TONE_W-1:0]   tone_r   [SLOT_COUNT];
  logic [FRAMES_W-1:0] frames_r [SLOT_COUNT];
  logic [DATA_W-1:0]   pend_r;
  logic                bank_r;
  logic [PHASE_W-1:0]  phase_r;
  logic [SAMPLE_W-1:0] sample_r;

  logic [FRAMES_W-1:0] cur_frames;
  logic                cur_busy;
  logic [2:0]          low_idx;
  logic [PHASE_W-1:0]  phase_sum;
  logic [SAMPLE_W-1:0] amp_ext;
  logic                any_busy;

  assign cur_frames = frames_r[cmd.ptr];
  assign cur_busy   = (cur_frames != '0);

  // lowest pending tone bit
  always_comb begin
    low_idx = '0;
    for (int b = DATA_W - 1; b >= 0; b--) begin
      if (pend_r[b]) begin
        low_idx = 3'(b);
      end
    end
  end

  always_comb begin
    any_busy = 1'b0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      any_busy = any_busy | (frames_r[i] != '0);
    end
  end

  assign phase_sum = phase_r + PHASE_STEP[tone_r[cmd.ptr]];
  assign amp_ext   = {1'b0, tone_amplitude};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        frames_r[i] <= '0;
      end
      phase_r <= '0;
    end else if (cmd.step) begin
      case (cmd.kind)
        WK_ALLOC: begin
          if (!cur_busy && pend_r != '0 && blip_length != '0) begin
            frames_r[cmd.ptr] <= blip_length;
          end
        end
        WK_AGE: begin
          if (cur_busy) begin
            frames_r[cmd.ptr] <= cur_frames - 1'b1;
          end
        end
        WK_SAMPLE: begin
          if (cur_busy) begin
            phase_r <= phase_sum;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload side, no reset
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      pend_r   <= tone_bits;
      bank_r   <= cmd.bank;
      sample_r <= '0;
    end else if (cmd.step) begin
      if (cmd.kind == WK_ALLOC && !cur_busy && pend_r != '0) begin
        tone_r[cmd.ptr] <= {bank_r, low_idx};
        pend_r          <= pend_r & (pend_r - 1'b1);
      end
      if (cmd.kind == WK_SAMPLE && cur_busy) begin
        sample_r <= phase_sum[PHASE_W-1] ? (~amp_ext + 1'b1) : amp_ext;
      end
    end
  end

  assign stat.hit        = cur_busy;
  assign stat.any_active = any_busy;
  assign sample          = sample_r;

  a_age_no_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && cmd.kind == WK_AGE) |=>
      (frames_r[$past(cmd.ptr)] <= $past(frames_r[cmd.ptr])))
    else $error("age step grew a slot");

  a_sample_keeps_slots: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && cmd.kind == WK_SAMPLE) |=> $stable(any_busy))
    else $error("sample step changed slot occupancy");

endmodule

@@ src/asp_ctrl.sv @@
// ----------------------------------------------------------------------------
// asp_ctrl
// sequencer that walks the tone slots for allocate, age and sample items
// ----------------------------------------------------------------------------
module asp_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [asp_pkg::OPCODE_W-1:0]  in_opcode,
  input  logic [asp_pkg::PORT_W-1:0]    in_port,
  input  asp_pkg::asp_slot_stat_t       stat,
  input  logic                          out_free,
  output logic                          in_ready,
  output logic                          commit,
  output asp_pkg::asp_slot_cmd_t        cmd
);
  import asp_pkg::*;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);

  asp_state_t        state_r, state_nxt;
  asp_walk_t         kind_r, kind_nxt;
  logic [SLOT_W-1:0] ptr_r, ptr_nxt;

  asp_op_t op;
  logic    accept;
  logic    is_tone;
  logic    needs_walk;
  logic    walk_end;

  assign op         = asp_op_t'(in_opcode);
  assign accept     = in_valid && in_ready;
  assign is_tone    = (in_port == PORT_TONE_A) || (in_port == PORT_TONE_B);
  assign needs_walk = (op == OP_TICK) || (op == OP_SAMPLE) || (op == OP_WRITE && is_tone);
  assign walk_end   = (ptr_r == LAST_SLOT) || (kind_r == WK_SAMPLE && stat.hit);

  always_comb begin
    case (op)
      OP_TICK:   kind_nxt = WK_AGE;
      OP_SAMPLE: kind_nxt = WK_SAMPLE;
      default:   kind_nxt = WK_ALLOC;
    endcase
    if (state_r != ST_IDLE) begin
      kind_nxt = kind_r;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    ptr_nxt   = ptr_r;
    case (state_r)
      ST_IDLE: begin
        ptr_nxt = '0;
        if (accept) begin
          state_nxt = needs_walk ? ST_WALK : ST_DONE;
        end
      end
      ST_WALK: begin
        if (walk_end) begin
          state_nxt = ST_DONE;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = 1'b0;
    commit    = 1'b0;
    cmd.start = 1'b0;
    cmd.step  = 1'b0;
    cmd.kind  = kind_r;
    cmd.bank  = (in_port == PORT_TONE_B);
    cmd.ptr   = ptr_r;
    case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      ST_WALK: cmd.step = 1'b1;
      ST_DONE: commit = out_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      kind_r  <= WK_ALLOC;
      ptr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
      ptr_r   <= ptr_nxt;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != ST_IDLE))
    else $error("sequencer idle right after a transfer");

  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (ptr_r <= LAST_SLOT))
    else $error("slot pointer past last slot");

endmodule

@@ src/arcade_shift_sound_port_device.sv @@
// ----------------------------------------------------------------------------
// arcade_shift_sound_port_device
// i/o port block: buttons, byte shift register, tone slots and tone generator
// ----------------------------------------------------------------------------
// One item at a time. A port read or a write to any port other than the two
// tone ports goes from idle straight to the done state and back to idle.
// A tone write (ports 3 and 5, whatever its data) and a frame tick walk every
// tone slot through one shared slot datapath, one slot a cycle. A sample
// request walks only up to the first active slot, where the one phase adder
// steps the accumulator, and walks every slot when no slot is active. Each
// result waits in an output register, so the next item is taken while the last
// result is still unclaimed; the sequencer holds only when a finished result
// finds that register full. Configuration writes land at once on cfg_we.
module arcade_shift_sound_port_device (
  input  logic                              clk,
  input  logic                              rst_n,
  asp_item_if.sink                          in_item,
  asp_result_if.source                      out_result,
  input  logic                              cfg_we,
  input  logic [asp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [asp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import asp_pkg::*;

  // configuration
  logic [FRAMES_W-1:0] blip_length_r;
  logic [AMP_W-1:0]    tone_amplitude_r;

  // shift register hardware
  logic [SHIFT_W-1:0]  shift_value_r;
  logic [AMT_W-1:0]    shift_amount_r;
  logic [SHIFT_W-1:0]  shift_window;

  // held read byte of the item in flight
  logic [DATA_W-1:0]   rd_hold_r;
  logic [DATA_W-1:0]   rd_nxt;
  logic [DATA_W-1:0]   button_byte;

  // output register
  logic                       out_valid_r;
  logic [DATA_W-1:0]          out_read_data_r;
  logic signed [SAMPLE_W-1:0] out_audio_sample_r;
  logic                       out_tone_active_r;

  logic                       in_ready;
  logic                       in_fire;
  logic                       out_free;
  logic                       commit;
  asp_slot_cmd_t              slot_cmd;
  asp_slot_stat_t             slot_stat;
  logic signed [SAMPLE_W-1:0] slot_sample;
  asp_op_t                    op;

  assign op       = asp_op_t'(in_item.opcode);
  assign in_fire  = in_item.valid && in_ready;
  assign out_free = !out_valid_r || out_result.ready;
  assign in_item.ready = in_ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blip_length_r    <= BLIP_RESET;
      tone_amplitude_r <= AMP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BLIP_LENGTH:    blip_length_r    <= cfg_wdata[FRAMES_W-1:0];
        CFG_TONE_AMPLITUDE: tone_amplitude_r <= cfg_wdata[AMP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // button port: coin, start, fire, left, right onto their board bits
  always_comb begin
    button_byte    = '0;
    button_byte[0] = in_item.buttons[4];
    button_byte[2] = in_item.buttons[3];
    button_byte[4] = in_item.buttons[2];
    button_byte[5] = in_item.buttons[0];
    button_byte[6] = in_item.buttons[1];
  end

  // shifted window: shift amount 0 gives the high byte, 7 the bits 8..1
  assign shift_window = shift_value_r >> (4'd8 - {1'b0, shift_amount_r});

  always_comb begin
    rd_nxt = '0;
    if (op == OP_READ) begin
      if (in_item.port == PORT_BUTTONS) begin
        rd_nxt = button_byte;
      end else if (in_item.port == PORT_SHIFT_RD) begin
        rd_nxt = shift_window[DATA_W-1:0];
      end
    end
  end

  // shift register writes take effect at the input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_value_r  <= '0;
      shift_amount_r <= '0;
    end else if (in_fire && op == OP_WRITE) begin
      if (in_item.port == PORT_SHIFT_AMT) begin
        shift_amount_r <= in_item.data[AMT_W-1:0];
      end else if (in_item.port == PORT_SHIFT_WR) begin
        shift_value_r <= {in_item.data, shift_value_r[SHIFT_W-1:DATA_W]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_hold_r <= rd_nxt;
    end
  end

  asp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_item.valid),
    .in_opcode (in_item.opcode),
    .in_port   (in_item.port),
    .stat      (slot_stat),
    .out_free  (out_free),
    .in_ready  (in_ready),
    .commit    (commit),
    .cmd       (slot_cmd)
  );

  asp_slot_unit u_slots (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (slot_cmd),
    .tone_bits      (in_item.data),
    .blip_length    (blip_length_r),
    .tone_amplitude (tone_amplitude_r),
    .stat           (slot_stat),
    .sample         (slot_sample)
  );

  // output register, loaded when the sequencer finishes an item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_result.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_read_data_r    <= rd_hold_r;
      out_audio_sample_r <= slot_sample;
      out_tone_active_r  <= slot_stat.any_active;
    end
  end

  assign out_result.valid        = out_valid_r;
  assign out_result.read_data    = out_read_data_r;
  assign out_result.audio_sample = out_audio_sample_r;
  assign out_result.tone_active  = out_tone_active_r;

  a_commit_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    commit |-> out_free)
    else $error("result loaded over an unclaimed transfer");

  a_sample_needs_tone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_audio_sample_r != '0) |-> out_tone_active_r)
    else $error("audio sample with no active tone");

endmodule

@@ dv/arcade_shift_sound_port_device_test.sv @@
// ----------------------------------------------------------------------------
// arcade_shift_sound_port_device_test
// self-checking bench for the arcade i/o port, shift register and tone block
// ----------------------------------------------------------------------------
// A queue of port items is filled by the stimulus process and drained by a
// clocked driver. The driver keeps a model of the buttons, the byte shift
// register, the tone slots and the phase accumulator, and it predicts one
// result for every item that it transfers. A clocked monitor compares every
// result transfer with the oldest prediction. The run covers several register
// settings, the extremes among them, under three patterns of back-pressure.
// ----------------------------------------------------------------------------
module arcade_shift_sound_port_device_test;
  timeunit 1ns;
  timeprecision 1ps;

  import asp_pkg::*;

  localparam int          WATCHDOG_LIMIT = 1000;
  localparam int          TAIL_CYCLES    = 20;
  localparam int          BATCH_ITEMS    = 150;
  localparam longint      SAMPLE_RATE_HZ = 48000;
  localparam int          TONE_HZ [16]   = '{
    120, 260, 520, 90, 700, 140, 60, 1100,
    180, 90, 320, 480, 220, 150, 800, 1000
  };

  typedef struct packed {
    asp_op_t              opcode;
    logic [PORT_W-1:0]    port;
    logic [DATA_W-1:0]    data;
    logic [BUTTONS_W-1:0] buttons;
  } port_item_t;

  typedef struct packed {
    logic [DATA_W-1:0]          read_data;
    logic signed [SAMPLE_W-1:0] audio_sample;
    logic                       tone_active;
  } port_result_t;

  // clock and the one reset at the start
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
  end

  // channels and the block itself
  asp_item_if   in_if ();
  asp_result_if out_if ();

  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  arcade_shift_sound_port_device dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_if),
    .out_result (out_if),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // bench-side copies of what goes onto the channels, known from time zero
  logic       drv_valid = 1'b0;
  port_item_t drv_item  = '0;
  logic       mon_ready = 1'b0;

  assign in_if.valid   = drv_valid;
  assign in_if.opcode  = drv_item.opcode;
  assign in_if.port    = drv_item.port;
  assign in_if.data    = drv_item.data;
  assign in_if.buttons = drv_item.buttons;
  assign out_if.ready  = mon_ready;

  // items waiting to go out, and results still owed by the block
  port_item_t   pending_items [$];
  port_result_t owed_results [$];

  // idling, in percent of cycles
  int src_idle_pct  = 0;
  int sink_idle_pct = 0;

  // run statistics
  int n_errors   = 0;
  int n_checked  = 0;
  int n_audible  = 0;
  int n_dropped  = 0;
  int n_settings = 1;
  int idle_cycles = 0;

  // model of the port block: registers first, then the state
  logic [FRAMES_W-1:0] mdl_blip = BLIP_RESET;
  logic [AMP_W-1:0]    mdl_amp  = AMP_RESET;
  logic [SHIFT_W-1:0]  mdl_shift_val = '0;
  logic [AMT_W-1:0]    mdl_shift_amt = '0;
  logic [TONE_W-1:0]   mdl_slot_tone [SLOT_COUNT] = '{default: '0};
  logic [FRAMES_W-1:0] mdl_slot_left [SLOT_COUNT] = '{default: '0};
  logic [PHASE_W-1:0]  mdl_phase = '0;

  // fraction of a cycle advanced per sample, halves rounded up
  function automatic logic [PHASE_W-1:0] tone_phase_inc(logic [TONE_W-1:0] tone);
    longint unsigned hz;
    hz = 64'(TONE_HZ[tone]);
    return PHASE_W'(((hz << 32) + SAMPLE_RATE_HZ / 2) / SAMPLE_RATE_HZ);
  endfunction

  function automatic int first_busy_slot();
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (mdl_slot_left[i] != '0) return i;
    end
    return -1;
  endfunction

  // each set bit claims the first free slot, or is lost when none is free
  function automatic void trigger_tones(logic [TONE_W-1:0] base, logic [DATA_W-1:0] bits);
    bit placed;
    for (int b = 0; b < 8; b++) begin
      if (bits[b]) begin
        placed = 1'b0;
        for (int i = 0; i < SLOT_COUNT && !placed; i++) begin
          if (mdl_slot_left[i] == '0) begin
            mdl_slot_tone[i] = base + TONE_W'(b);
            mdl_slot_left[i] = mdl_blip;
            placed = 1'b1;
          end
        end
        if (!placed) n_dropped++;
      end
    end
  endfunction

  function automatic port_result_t predict_port_item(port_item_t it);
    port_result_t            r;
    int                      act;
    logic signed [SAMPLE_W-1:0] mag;
    r = '0;
    case (it.opcode)
      OP_READ: begin
        if (it.port == PORT_BUTTONS) begin
          // coin, start, fire, left, right onto their active-high bits
          r.read_data[0] = it.buttons[4];
          r.read_data[2] = it.buttons[3];
          r.read_data[4] = it.buttons[2];
          r.read_data[5] = it.buttons[0];
          r.read_data[6] = it.buttons[1];
        end else if (it.port == PORT_SHIFT_RD) begin
          r.read_data = DATA_W'(mdl_shift_val >> (4'd8 - {1'b0, mdl_shift_amt}));
        end
      end
      OP_WRITE: begin
        if (it.port == PORT_SHIFT_AMT) mdl_shift_amt = it.data[AMT_W-1:0];
        else if (it.port == PORT_TONE_A) trigger_tones(4'd0, it.data);
        else if (it.port == PORT_SHIFT_WR) mdl_shift_val = {it.data, mdl_shift_val[15:8]};
        else if (it.port == PORT_TONE_B) trigger_tones(4'd8, it.data);
      end
      OP_TICK: begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (mdl_slot_left[i] != '0) mdl_slot_left[i]--;
        end
      end
      default: begin
        // an idle request leaves the phase where it was
        act = first_busy_slot();
        if (act >= 0) begin
          mdl_phase = mdl_phase + tone_phase_inc(mdl_slot_tone[act]);
          mag = $signed({1'b0, mdl_amp});
          r.audio_sample = mdl_phase[31] ? -mag : mag;
          n_audible++;
        end
      end
    endcase
    r.tone_active = (first_busy_slot() >= 0);
    return r;
  endfunction

  // driver: a valid item is held until its transfer, gaps only in between
  always @(posedge clk) begin
    if (!rst_n) begin
      drv_valid <= 1'b0;
    end else begin
      if (drv_valid && in_if.ready) begin
        owed_results.push_back(predict_port_item(drv_item));
      end
      if (!drv_valid || in_if.ready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          drv_item  <= pending_items.pop_front();
          drv_valid <= 1'b1;
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: every result transfer against the oldest prediction
  always @(posedge clk) begin
    port_result_t want;
    if (!rst_n) begin
      mon_ready <= 1'b0;
    end else begin
      if (mon_ready && out_if.valid) begin
        if (owed_results.size() == 0) begin
          $display("%0t: result with nothing owed, got rd %h smp %0d act %b", $realtime,
                   out_if.read_data, out_if.audio_sample, out_if.tone_active);
          n_errors++;
        end else begin
          want = owed_results.pop_front();
          n_checked++;
          if (out_if.read_data !== want.read_data) begin
            $display("%0t: read_data expected %h actual %h", $realtime,
                     want.read_data, out_if.read_data);
            n_errors++;
          end
          if (out_if.audio_sample !== want.audio_sample) begin
            $display("%0t: audio_sample expected %0d actual %0d", $realtime,
                     want.audio_sample, out_if.audio_sample);
            n_errors++;
          end
          if (out_if.tone_active !== want.tone_active) begin
            $display("%0t: tone_active expected %b actual %b", $realtime,
                     want.tone_active, out_if.tone_active);
            n_errors++;
          end
        end
      end
      mon_ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // watchdog: cycles in a row with no transfer on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("%0t: no transfer for %0d cycles, %0d results still owed", $realtime,
             WATCHDOG_LIMIT, owed_results.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic port_item_t mk_item(asp_op_t op, logic [PORT_W-1:0] port,
                                         logic [DATA_W-1:0] data,
                                         logic [BUTTONS_W-1:0] buttons);
    port_item_t it;
    it.opcode  = op;
    it.port    = port;
    it.data    = data;
    it.buttons = buttons;
    return it;
  endfunction

  // mostly well-formed traffic: tone writes, ticks, samples, shift use; some noise
  function automatic port_item_t random_item();
    port_item_t it;
    int         pick;
    pick       = $urandom_range(99);
    it.port    = PORT_W'($urandom);
    it.data    = DATA_W'($urandom);
    it.buttons = BUTTONS_W'($urandom);
    if (pick < 20) begin
      it.opcode = OP_SAMPLE;
    end else if (pick < 35) begin
      it.opcode = OP_TICK;
    end else if (pick < 57) begin
      it.opcode = OP_WRITE;
      it.port   = $urandom_range(1) ? PORT_TONE_A : PORT_TONE_B;
      // sparse bytes keep slots from saturating
      if ($urandom_range(2) != 0)
        it.data = (8'd1 << $urandom_range(7)) | ($urandom_range(3) == 0 ? it.data & 8'h11 : 8'h00);
    end else if (pick < 67) begin
      it.opcode = OP_WRITE;
      it.port   = PORT_SHIFT_WR;
    end else if (pick < 72) begin
      it.opcode = OP_WRITE;
      it.port   = PORT_SHIFT_AMT;
    end else if (pick < 87) begin
      it.opcode = OP_READ;
      it.port   = $urandom_range(1) ? PORT_BUTTONS : PORT_SHIFT_RD;
    end else begin
      it.opcode = asp_op_t'($urandom_range(3));
    end
    return it;
  endfunction

  // wait until nothing is queued, nothing is on the wire and nothing is owed
  task automatic drain_all();
    do @(negedge clk);
    while (pending_items.size() != 0 || drv_valid || owed_results.size() != 0);
  endtask

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) begin
      pending_items.push_back(random_item());
      // sender holds off now and then until every result is home
      if (i % BATCH_ITEMS == BATCH_ITEMS - 1) drain_all();
    end
  endtask

  // both registers in back-to-back write cycles, block idle throughout
  task automatic load_settings(logic [FRAMES_W-1:0] blip, logic [AMP_W-1:0] amp);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_BLIP_LENGTH;
    cfg_wdata <= CFG_DATA_W'(blip);
    @(posedge clk);
    cfg_index <= CFG_TONE_AMPLITUDE;
    cfg_wdata <= CFG_DATA_W'(amp);
    @(posedge clk);
    cfg_we    <= 1'b0;
    mdl_blip = blip;
    mdl_amp  = amp;
    n_settings++;
  endtask

  initial begin
    do @(negedge clk);
    while (!rst_n);

    // sender sparse gaps, receiver mostly stalled
    src_idle_pct  = 14;
    sink_idle_pct = 69;

    // directed part at reset settings
    pending_items.push_back(mk_item(OP_READ,   PORT_BUTTONS, 8'h00, 5'h1f));
    pending_items.push_back(mk_item(OP_READ,   PORT_BUTTONS, 8'hff, 5'h00));
    pending_items.push_back(mk_item(OP_READ,   PORT_BUTTONS, 8'h00, 5'h15));
    pending_items.push_back(mk_item(OP_READ,   PORT_BUTTONS, 8'h00, 5'h0a));
    pending_items.push_back(mk_item(OP_READ,   8'h00,        8'h00, 5'h1f));
    pending_items.push_back(mk_item(OP_READ,   8'hff,        8'hff, 5'h1f));
    // sample request with every slot free
    pending_items.push_back(mk_item(OP_SAMPLE, 8'h00,        8'h00, 5'h00));
    pending_items.push_back(mk_item(OP_WRITE,  PORT_SHIFT_WR, 8'ha5, 5'h00));
    pending_items.push_back(mk_item(OP_WRITE,  PORT_SHIFT_WR, 8'h3c, 5'h00));
    pending_items.push_back(mk_item(OP_READ,   PORT_SHIFT_RD, 8'h00, 5'h00));
    pending_items.push_back(mk_item(OP_WRITE,  PORT_SHIFT_AMT, 8'hff, 5'h00));
    pending_items.push_back(mk_item(OP_READ,   PORT_SHIFT_RD, 8'h00, 5'h00));
    pending_items.push_back(mk_item(OP_WRITE,  PORT_SHIFT_AMT, 8'h05, 5'h00));
    pending_items.push_back(mk_item(OP_READ,   PORT_SHIFT_RD, 8'h00, 5'h00));
    // writes to ports that do nothing
    pending_items.push_back(mk_item(OP_WRITE,  8'h00,        8'hff, 5'h1f));
    pending_items.push_back(mk_item(OP_WRITE,  8'hff,        8'h00, 5'h00));
    // fill all slots, then a full bank with none free
    pending_items.push_back(mk_item(OP_WRITE,  PORT_TONE_A,  8'hff, 5'h00));
    pending_items.push_back(mk_item(OP_WRITE,  PORT_TONE_B,  8'hff, 5'h00));
    pending_items.push_back(mk_item(OP_SAMPLE, 8'hff,        8'hff, 5'h1f));
    pending_items.push_back(mk_item(OP_SAMPLE, 8'h00,        8'h00, 5'h00));
    // age past the blip length, free slots stay free
    for (int i = 0; i < 5; i++)
      pending_items.push_back(mk_item(OP_TICK, 8'h00, 8'h00, 5'h00));
    pending_items.push_back(mk_item(OP_SAMPLE, 8'h00,        8'h00, 5'h00));
    run_random(300);

    drain_all();
    load_settings(4'd15, 15'd32767);
    run_random(300);

    // receiver mostly ready, sender gappy
    drain_all();
    src_idle_pct  = 69;
    sink_idle_pct = 14;
    load_settings(4'd1, 15'd0);
    run_random(300);

    // zero blip length: a triggered tone leaves its slot free
    drain_all();
    load_settings(4'd0, 15'd12000);
    pending_items.push_back(mk_item(OP_WRITE,  PORT_TONE_A,  8'h81, 5'h00));
    pending_items.push_back(mk_item(OP_WRITE,  PORT_TONE_B,  8'h01, 5'h00));
    pending_items.push_back(mk_item(OP_SAMPLE, 8'h00,        8'h00, 5'h00));
    pending_items.push_back(mk_item(OP_TICK,   8'h00,        8'h00, 5'h00));
    run_random(60);

    // no idling on either side
    drain_all();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    load_settings(4'd9, 15'd1);
    run_random(300);

    drain_all();
    load_settings(FRAMES_W'($urandom_range(15, 1)), AMP_W'($urandom_range(32767)));
    run_random(540);

    drain_all();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("checked %0d results across %0d register settings and three idling patterns",
             n_checked, n_settings);
    $display("%0d audible samples, %0d tone triggers lost for want of a free slot",
             n_audible, n_dropped);
    if (n_errors == 0 && owed_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results never arrived", n_errors, owed_results.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
